### src/amp_pkg.sv
// Package: shared types, constants and the microprogram of the affine matrix unit.
package amp_pkg;

	localparam int FRAC_BITS = 16;
	localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC_BITS;
	// rounded product width and accumulator width (three terms plus sign)
	localparam int TERM_W = 64 - FRAC_BITS;
	localparam int ACC_W = TERM_W + 3;
	// reciprocal numerator 2^(2F) + m/2 and its quotient
	localparam int NUM_W = 2 * FRAC_BITS + 2;
	localparam int CNT_W = $clog2(NUM_W + 1);

	typedef enum logic [3:0] {
		OP_XFORM, OP_XFORM2, OP_INVXFORM, OP_TRANSLATE, OP_SCALE, OP_ROTATE,
		OP_SHEAR, OP_INVERT, OP_FLIPX, OP_FLIPY, OP_RESET, OP_MULTIPLY,
		OP_LOAD, OP_COMPARE, OP_DET, OP_NOP
	} op_t;

	typedef struct packed {
		logic [3:0] opcode;
		logic signed [31:0] arg_x;
		logic signed [31:0] arg_y;
		logic signed [31:0] op_sx;
		logic signed [31:0] op_shy;
		logic signed [31:0] op_shx;
		logic signed [31:0] op_sy;
		logic signed [31:0] op_tx;
		logic signed [31:0] op_ty;
	} req_t;

	typedef struct packed {
		logic signed [31:0] res_x;
		logic signed [31:0] res_y;
		logic signed [31:0] det_value;
		logic is_ident;
		logic is_same;
		logic singular;
		logic saturated;
	} rsp_t;

	typedef enum logic [4:0] {
		S_SX, S_SHY, S_SHX, S_SY, S_TX, S_TY, S_T0, S_T1, S_T2,
		S_AX, S_AY, S_AXT, S_AYT,
		S_OSX, S_OSHY, S_OSHX, S_OSY, S_OTX, S_OTY,
		S_ONE, S_ZERO
	} src_t;

	typedef enum logic [3:0] {
		D_SX, D_SHY, D_SHX, D_SY, D_TX, D_TY, D_T0, D_T1, D_T2,
		D_RX, D_RY, D_DET, D_NONE
	} dst_t;

	typedef enum logic [1:0] {K_TERM, K_RECIP, K_END} kind_t;

	typedef struct packed {
		kind_t kind;
		src_t a;
		src_t b;
		logic neg;
		logic first;
		dst_t dst;
	} uop_t;

	localparam uop_t U_END = '{kind: K_END, a: S_ZERO, b: S_ZERO, neg: 1'b0,
		first: 1'b0, dst: D_NONE};
	localparam uop_t U_RECIP = '{kind: K_RECIP, a: S_ZERO, b: S_ZERO, neg: 1'b0,
		first: 1'b0, dst: D_NONE};

	// one product term: acc = (first ? 0 : acc) +/- a*b, then store if dst given
	function automatic uop_t mt(src_t a, src_t b, logic ng, logic fi, dst_t d);
		uop_t u;
		u.kind = K_TERM;
		u.a = a;
		u.b = b;
		u.neg = ng;
		u.first = fi;
		u.dst = d;
		return u;
	endfunction

	function automatic uop_t ucode(logic [3:0] opc, logic [4:0] pc, logic tail);
		uop_t u;
		u = U_END;
		if (tail) begin
			// determinant of the matrix as it stands after the step
			case (pc)
			5'd0: u = mt(S_SX, S_SY, 1'b0, 1'b1, D_NONE);
			5'd1: u = mt(S_SHY, S_SHX, 1'b1, 1'b0, D_DET);
			default: u = U_END;
			endcase
		end else begin
			case (op_t'(opc))
			OP_XFORM: begin
				case (pc)
				5'd0: u = mt(S_AX, S_SX, 1'b0, 1'b1, D_NONE);
				5'd1: u = mt(S_AY, S_SHX, 1'b0, 1'b0, D_NONE);
				5'd2: u = mt(S_TX, S_ONE, 1'b0, 1'b0, D_RX);
				5'd3: u = mt(S_AX, S_SHY, 1'b0, 1'b1, D_NONE);
				5'd4: u = mt(S_AY, S_SY, 1'b0, 1'b0, D_NONE);
				5'd5: u = mt(S_TY, S_ONE, 1'b0, 1'b0, D_RY);
				default: u = U_END;
				endcase
			end
			OP_XFORM2: begin
				case (pc)
				5'd0: u = mt(S_AX, S_SX, 1'b0, 1'b1, D_NONE);
				5'd1: u = mt(S_AY, S_SHX, 1'b0, 1'b0, D_RX);
				5'd2: u = mt(S_AX, S_SHY, 1'b0, 1'b1, D_NONE);
				5'd3: u = mt(S_AY, S_SY, 1'b0, 1'b0, D_RY);
				default: u = U_END;
				endcase
			end
			OP_INVXFORM: begin
				case (pc)
				5'd0: u = mt(S_SX, S_SY, 1'b0, 1'b1, D_NONE);
				5'd1: u = mt(S_SHY, S_SHX, 1'b1, 1'b0, D_T2);
				5'd2: u = U_RECIP;
				5'd3: u = mt(S_AXT, S_T2, 1'b0, 1'b1, D_T0);
				5'd4: u = mt(S_AYT, S_T2, 1'b0, 1'b1, D_T1);
				5'd5: u = mt(S_T0, S_SY, 1'b0, 1'b1, D_NONE);
				5'd6: u = mt(S_T1, S_SHX, 1'b1, 1'b0, D_RX);
				5'd7: u = mt(S_T1, S_SX, 1'b0, 1'b1, D_NONE);
				5'd8: u = mt(S_T0, S_SHY, 1'b1, 1'b0, D_RY);
				default: u = U_END;
				endcase
			end
			OP_TRANSLATE: begin
				case (pc)
				5'd0: u = mt(S_TX, S_ONE, 1'b0, 1'b1, D_NONE);
				5'd1: u = mt(S_AX, S_ONE, 1'b0, 1'b0, D_TX);
				5'd2: u = mt(S_TY, S_ONE, 1'b0, 1'b1, D_NONE);
				5'd3: u = mt(S_AY, S_ONE, 1'b0, 1'b0, D_TY);
				default: u = U_END;
				endcase
			end
			OP_SCALE: begin
				case (pc)
				5'd0: u = mt(S_SX, S_AX, 1'b0, 1'b1, D_SX);
				5'd1: u = mt(S_SHX, S_AX, 1'b0, 1'b1, D_SHX);
				5'd2: u = mt(S_TX, S_AX, 1'b0, 1'b1, D_TX);
				5'd3: u = mt(S_SHY, S_AY, 1'b0, 1'b1, D_SHY);
				5'd4: u = mt(S_SY, S_AY, 1'b0, 1'b1, D_SY);
				5'd5: u = mt(S_TY, S_AY, 1'b0, 1'b1, D_TY);
				default: u = U_END;
				endcase
			end
			OP_ROTATE: begin
				case (pc)
				5'd0: u = mt(S_SX, S_AX, 1'b0, 1'b1, D_NONE);
				5'd1: u = mt(S_SHY, S_AY, 1'b1, 1'b0, D_T0);
				5'd2: u = mt(S_SHX, S_AX, 1'b0, 1'b1, D_NONE);
				5'd3: u = mt(S_SY, S_AY, 1'b1, 1'b0, D_T1);
				5'd4: u = mt(S_TX, S_AX, 1'b0, 1'b1, D_NONE);
				5'd5: u = mt(S_TY, S_AY, 1'b1, 1'b0, D_T2);
				5'd6: u = mt(S_SX, S_AY, 1'b0, 1'b1, D_NONE);
				5'd7: u = mt(S_SHY, S_AX, 1'b0, 1'b0, D_SHY);
				5'd8: u = mt(S_SHX, S_AY, 1'b0, 1'b1, D_NONE);
				5'd9: u = mt(S_SY, S_AX, 1'b0, 1'b0, D_SY);
				5'd10: u = mt(S_TX, S_AY, 1'b0, 1'b1, D_NONE);
				5'd11: u = mt(S_TY, S_AX, 1'b0, 1'b0, D_TY);
				5'd12: u = mt(S_T0, S_ONE, 1'b0, 1'b1, D_SX);
				5'd13: u = mt(S_T1, S_ONE, 1'b0, 1'b1, D_SHX);
				5'd14: u = mt(S_T2, S_ONE, 1'b0, 1'b1, D_TX);
				default: u = U_END;
				endcase
			end
			OP_SHEAR: begin
				case (pc)
				5'd0: u = mt(S_SX, S_ONE, 1'b0, 1'b1, D_NONE);
				5'd1: u = mt(S_AY, S_SHX, 1'b0, 1'b0, D_T0);
				5'd2: u = mt(S_SHY, S_ONE, 1'b0, 1'b1, D_NONE);
				5'd3: u = mt(S_AY, S_SY, 1'b0, 1'b0, D_T1);
				5'd4: u = mt(S_SHX, S_ONE, 1'b0, 1'b1, D_NONE);
				5'd5: u = mt(S_AX, S_SX, 1'b0, 1'b0, D_T2);
				5'd6: u = mt(S_SY, S_ONE, 1'b0, 1'b1, D_NONE);
				5'd7: u = mt(S_AX, S_SHY, 1'b0, 1'b0, D_SY);
				5'd8: u = mt(S_T0, S_ONE, 1'b0, 1'b1, D_SX);
				5'd9: u = mt(S_T1, S_ONE, 1'b0, 1'b1, D_SHY);
				5'd10: u = mt(S_T2, S_ONE, 1'b0, 1'b1, D_SHX);
				default: u = U_END;
				endcase
			end
			OP_INVERT: begin
				case (pc)
				5'd0: u = mt(S_SX, S_SY, 1'b0, 1'b1, D_NONE);
				5'd1: u = mt(S_SHY, S_SHX, 1'b1, 1'b0, D_T2);
				5'd2: u = U_RECIP;
				5'd3: u = mt(S_SY, S_T2, 1'b0, 1'b1, D_T0);
				5'd4: u = mt(S_SX, S_T2, 1'b0, 1'b1, D_SY);
				5'd5: u = mt(S_SHY, S_T2, 1'b1, 1'b1, D_SHY);
				5'd6: u = mt(S_SHX, S_T2, 1'b1, 1'b1, D_SHX);
				5'd7: u = mt(S_TX, S_T0, 1'b1, 1'b1, D_NONE);
				5'd8: u = mt(S_TY, S_SHX, 1'b1, 1'b0, D_T1);
				5'd9: u = mt(S_TX, S_SHY, 1'b1, 1'b1, D_NONE);
				5'd10: u = mt(S_TY, S_SY, 1'b1, 1'b0, D_TY);
				5'd11: u = mt(S_T0, S_ONE, 1'b0, 1'b1, D_SX);
				5'd12: u = mt(S_T1, S_ONE, 1'b0, 1'b1, D_TX);
				default: u = U_END;
				endcase
			end
			OP_FLIPX: begin
				case (pc)
				5'd0: u = mt(S_SX, S_ONE, 1'b1, 1'b1, D_SX);
				5'd1: u = mt(S_SHY, S_ONE, 1'b1, 1'b1, D_SHY);
				5'd2: u = mt(S_TX, S_ONE, 1'b1, 1'b1, D_TX);
				default: u = U_END;
				endcase
			end
			OP_FLIPY: begin
				case (pc)
				5'd0: u = mt(S_SHX, S_ONE, 1'b1, 1'b1, D_SHX);
				5'd1: u = mt(S_SY, S_ONE, 1'b1, 1'b1, D_SY);
				5'd2: u = mt(S_TY, S_ONE, 1'b1, 1'b1, D_TY);
				default: u = U_END;
				endcase
			end
			OP_RESET: begin
				case (pc)
				5'd0: u = mt(S_ONE, S_ONE, 1'b0, 1'b1, D_SX);
				5'd1: u = mt(S_ZERO, S_ONE, 1'b0, 1'b1, D_SHY);
				5'd2: u = mt(S_ZERO, S_ONE, 1'b0, 1'b1, D_SHX);
				5'd3: u = mt(S_ONE, S_ONE, 1'b0, 1'b1, D_SY);
				5'd4: u = mt(S_ZERO, S_ONE, 1'b0, 1'b1, D_TX);
				5'd5: u = mt(S_ZERO, S_ONE, 1'b0, 1'b1, D_TY);
				default: u = U_END;
				endcase
			end
			OP_MULTIPLY: begin
				case (pc)
				5'd0: u = mt(S_SX, S_OSX, 1'b0, 1'b1, D_NONE);
				5'd1: u = mt(S_SHY, S_OSHX, 1'b0, 1'b0, D_T0);
				5'd2: u = mt(S_SHX, S_OSX, 1'b0, 1'b1, D_NONE);
				5'd3: u = mt(S_SY, S_OSHX, 1'b0, 1'b0, D_T1);
				5'd4: u = mt(S_TX, S_OSX, 1'b0, 1'b1, D_NONE);
				5'd5: u = mt(S_TY, S_OSHX, 1'b0, 1'b0, D_NONE);
				5'd6: u = mt(S_OTX, S_ONE, 1'b0, 1'b0, D_T2);
				5'd7: u = mt(S_SX, S_OSHY, 1'b0, 1'b1, D_NONE);
				5'd8: u = mt(S_SHY, S_OSY, 1'b0, 1'b0, D_SHY);
				5'd9: u = mt(S_SHX, S_OSHY, 1'b0, 1'b1, D_NONE);
				5'd10: u = mt(S_SY, S_OSY, 1'b0, 1'b0, D_SY);
				5'd11: u = mt(S_TX, S_OSHY, 1'b0, 1'b1, D_NONE);
				5'd12: u = mt(S_TY, S_OSY, 1'b0, 1'b0, D_NONE);
				5'd13: u = mt(S_OTY, S_ONE, 1'b0, 1'b0, D_TY);
				5'd14: u = mt(S_T0, S_ONE, 1'b0, 1'b1, D_SX);
				5'd15: u = mt(S_T1, S_ONE, 1'b0, 1'b1, D_SHX);
				5'd16: u = mt(S_T2, S_ONE, 1'b0, 1'b1, D_TX);
				default: u = U_END;
				endcase
			end
			OP_LOAD: begin
				case (pc)
				5'd0: u = mt(S_OSX, S_ONE, 1'b0, 1'b1, D_SX);
				5'd1: u = mt(S_OSHY, S_ONE, 1'b0, 1'b1, D_SHY);
				5'd2: u = mt(S_OSHX, S_ONE, 1'b0, 1'b1, D_SHX);
				5'd3: u = mt(S_OSY, S_ONE, 1'b0, 1'b1, D_SY);
				5'd4: u = mt(S_OTX, S_ONE, 1'b0, 1'b1, D_TX);
				5'd5: u = mt(S_OTY, S_ONE, 1'b0, 1'b1, D_TY);
				default: u = U_END;
				endcase
			end
			default: u = U_END;
			endcase
		end
		return u;
	endfunction

endpackage

### src/amp_mac.sv
// Shared multiply, round, accumulate and saturate unit.
module amp_mac (
	input  logic clk,
	input  logic arst_n,
	input  logic mul_en,
	input  logic acc_en,
	input  logic signed [32:0] a,
	input  logic signed [31:0] b,
	input  logic neg,
	input  logic first,
	output logic signed [31:0] res,
	output logic sat
);
	import amp_pkg::*;

	localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] ACC_MIN = -(ACC_W'(64'sd2147483648));

	logic [32:0] mag_a;
	logic [31:0] mag_b;
	logic [63:0] prod_s1;
	logic neg_s1;
	logic first_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic [63:0] rnd;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] acc_next;

	assign mag_a = a[32] ? 33'(-a) : 33'(a);
	assign mag_b = b[31] ? 32'(-b) : 32'(b);

	// round half away from zero on the magnitude, then apply the sign
	assign rnd = prod_s1 + (64'd1 << (FRAC_BITS - 1));
	assign term = neg_s1 ? -(ACC_W'(rnd[63:FRAC_BITS])) : ACC_W'(rnd[63:FRAC_BITS]);
	assign acc_next = (first_s1 ? '0 : acc_q) + term;

	always_comb begin
		res = acc_next[31:0];
		sat = 1'b0;
		if (acc_next > ACC_MAX) begin
			res = ACC_MAX[31:0];
			sat = 1'b1;
		end else if (acc_next < ACC_MIN) begin
			res = ACC_MIN[31:0];
			sat = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_s1 <= '0;
			neg_s1 <= 1'b0;
			first_s1 <= 1'b0;
			acc_q <= '0;
		end else begin
			if (mul_en) begin
				prod_s1 <= {31'd0, mag_a} * {32'd0, mag_b};
				neg_s1 <= a[32] ^ b[31] ^ neg;
				first_s1 <= first;
			end
			if (acc_en) begin
				acc_q <= acc_next;
			end
		end
	end

endmodule

### src/amp_recip.sv
// Restoring divider for the saturated reciprocal 2^(2F)/det, one quotient bit per cycle.
module amp_recip (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [31:0] det,
	output logic done,
	output logic signed [31:0] q,
	output logic sat
);
	import amp_pkg::*;

	localparam logic [NUM_W-1:0] POS_MAX = NUM_W'(64'd2147483647);
	localparam logic [NUM_W-1:0] NEG_MAX = NUM_W'(64'd2147483648);

	logic busy_q;
	logic done_q;
	logic neg_q;
	logic [31:0] mag_q;
	logic [31:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0] mag_in;
	logic [32:0] rem_sh;
	logic fits;

	assign mag_in = det[31] ? 32'(-det) : 32'(det);
	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign fits = rem_sh >= {1'b0, mag_q};
	assign done = done_q;

	always_comb begin
		sat = 1'b0;
		q = neg_q ? -(quo_q[31:0]) : quo_q[31:0];
		if (!neg_q && quo_q > POS_MAX) begin
			q = 32'sh7fffffff;
			sat = 1'b1;
		end else if (neg_q && quo_q > NEG_MAX) begin
			q = 32'sh80000000;
			sat = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q <= 1'b0;
			mag_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				neg_q <= det[31];
				mag_q <= mag_in;
				rem_q <= '0;
				quo_q <= (NUM_W'(1) << (2 * FRAC_BITS)) + NUM_W'(mag_in >> 1);
				cnt_q <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				// shift in one numerator bit, subtract where the divisor fits
				rem_q <= fits ? 32'(rem_sh - {1'b0, mag_q}) : rem_sh[31:0];
				quo_q <= {quo_q[NUM_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### src/affine_matrix_point_unit.sv
// Top level: matrix registers, microsequencer and result register of the affine unit.
//
//  channel | signals                    | direction | transfer when
//  --------+----------------------------+-----------+-------------------------
//  request | req_valid, req_stall, req  | in        | req_valid && !req_stall
//  result  | rsp_valid, rsp_stall, rsp  | out       | rsp_valid && !rsp_stall
//
// One item at a time. Each product term passes through the multiply state
// and then the accumulate state of the shared multiply-accumulate unit;
// the closing determinant adds two more terms. Invert and inverse transform
// also run the reciprocal divider, 2*FRAC_BITS+2 steps, unless the determinant
// is zero. Reset loads the identity matrix. A waiting result does not block
// the next transfer in; a finished item holds until the result register is
// free.
module affine_matrix_point_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  amp_pkg::req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output amp_pkg::rsp_t rsp
);
	import amp_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ACC, ST_REC} state_t;

	state_t state_q;
	req_t req_q;
	logic [4:0] pc_q;
	logic tail_q;
	logic signed [31:0] sx_q, shy_q, shx_q, sy_q, tx_q, ty_q;
	logic signed [31:0] t0_q, t1_q, t2_q, rx_q, ry_q, det_q;
	logic same_q, sing_q, sat_q;
	uop_t uop;
	logic signed [32:0] opa;
	logic signed [32:0] opb_w;
	logic signed [31:0] mac_res;
	logic mac_sat;
	logic rec_start;
	logic rec_done;
	logic signed [31:0] rec_q;
	logic rec_sat;
	logic ident;
	logic eq;
	logic out_free;
	logic rsp_load;

	function automatic logic signed [32:0] src_val(src_t s);
		logic signed [32:0] v;
		case (s)
		S_SX: v = 33'(sx_q);
		S_SHY: v = 33'(shy_q);
		S_SHX: v = 33'(shx_q);
		S_SY: v = 33'(sy_q);
		S_TX: v = 33'(tx_q);
		S_TY: v = 33'(ty_q);
		S_T0: v = 33'(t0_q);
		S_T1: v = 33'(t1_q);
		S_T2: v = 33'(t2_q);
		S_AX: v = 33'(req_q.arg_x);
		S_AY: v = 33'(req_q.arg_y);
		S_AXT: v = 33'(req_q.arg_x) - 33'(tx_q);
		S_AYT: v = 33'(req_q.arg_y) - 33'(ty_q);
		S_OSX: v = 33'(req_q.op_sx);
		S_OSHY: v = 33'(req_q.op_shy);
		S_OSHX: v = 33'(req_q.op_shx);
		S_OSY: v = 33'(req_q.op_sy);
		S_OTX: v = 33'(req_q.op_tx);
		S_OTY: v = 33'(req_q.op_ty);
		S_ONE: v = 33'(Q_ONE);
		default: v = '0;
		endcase
		return v;
	endfunction

	assign uop = ucode(req_q.opcode, pc_q, tail_q);
	assign opa = src_val(uop.a);
	assign opb_w = src_val(uop.b);
	assign rec_start = (state_q == ST_MUL) && (uop.kind == K_RECIP) && (t2_q != '0);
	assign out_free = !rsp_valid || !rsp_stall;
	assign rsp_load = (state_q == ST_MUL) && (uop.kind == K_END) && tail_q && out_free;
	assign req_stall = (state_q != ST_IDLE);

	assign ident = (sx_q == Q_ONE) && (sy_q == Q_ONE) && (shy_q == '0) &&
		(shx_q == '0) && (tx_q == '0) && (ty_q == '0);
	assign eq = (sx_q == req.op_sx) && (shy_q == req.op_shy) &&
		(shx_q == req.op_shx) && (sy_q == req.op_sy) &&
		(tx_q == req.op_tx) && (ty_q == req.op_ty);

	amp_mac u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.mul_en((state_q == ST_MUL) && (uop.kind == K_TERM)),
		.acc_en(state_q == ST_ACC),
		.a(opa),
		.b(opb_w[31:0]),
		.neg(uop.neg),
		.first(uop.first),
		.res(mac_res),
		.sat(mac_sat)
	);

	amp_recip u_recip (
		.clk(clk),
		.arst_n(arst_n),
		.start(rec_start),
		.det(t2_q),
		.done(rec_done),
		.q(rec_q),
		.sat(rec_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			req_q <= '0;
			pc_q <= '0;
			tail_q <= 1'b0;
			sx_q <= Q_ONE;
			shy_q <= '0;
			shx_q <= '0;
			sy_q <= Q_ONE;
			tx_q <= '0;
			ty_q <= '0;
			t0_q <= '0;
			t1_q <= '0;
			t2_q <= '0;
			rx_q <= '0;
			ry_q <= '0;
			det_q <= '0;
			same_q <= 1'b0;
			sing_q <= 1'b0;
			sat_q <= 1'b0;
			rsp_valid <= 1'b0;
			rsp <= '0;
		end else begin
			if (rsp_valid && !rsp_stall && !rsp_load) begin
				rsp_valid <= 1'b0;
			end
			case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					req_q <= req;
					pc_q <= '0;
					tail_q <= 1'b0;
					rx_q <= '0;
					ry_q <= '0;
					sing_q <= 1'b0;
					sat_q <= 1'b0;
					same_q <= (op_t'(req.opcode) == OP_COMPARE) && eq;
					state_q <= ST_MUL;
				end
			end
			ST_MUL: begin
				case (uop.kind)
				K_TERM: state_q <= ST_ACC;
				K_RECIP: begin
					if (t2_q == '0) begin
						// zero determinant: skip to the closing determinant
						sing_q <= 1'b1;
						tail_q <= 1'b1;
						pc_q <= '0;
					end else begin
						state_q <= ST_REC;
					end
				end
				K_END: begin
					if (!tail_q) begin
						tail_q <= 1'b1;
						pc_q <= '0;
					end else if (out_free) begin
						rsp_valid <= 1'b1;
						rsp.res_x <= rx_q;
						rsp.res_y <= ry_q;
						rsp.det_value <= det_q;
						rsp.is_ident <= ident;
						rsp.is_same <= same_q;
						rsp.singular <= sing_q;
						rsp.saturated <= sat_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
				endcase
			end
			ST_ACC: begin
				pc_q <= pc_q + 5'd1;
				state_q <= ST_MUL;
				if (uop.dst != D_NONE) begin
					sat_q <= sat_q | mac_sat;
				end
				case (uop.dst)
				D_SX: sx_q <= mac_res;
				D_SHY: shy_q <= mac_res;
				D_SHX: shx_q <= mac_res;
				D_SY: sy_q <= mac_res;
				D_TX: tx_q <= mac_res;
				D_TY: ty_q <= mac_res;
				D_T0: t0_q <= mac_res;
				D_T1: t1_q <= mac_res;
				D_T2: t2_q <= mac_res;
				D_RX: rx_q <= mac_res;
				D_RY: ry_q <= mac_res;
				D_DET: det_q <= mac_res;
				default: ;
				endcase
			end
			ST_REC: begin
				if (rec_done) begin
					t2_q <= rec_q;
					sat_q <= sat_q | rec_sat;
					pc_q <= pc_q + 5'd1;
					state_q <= ST_MUL;
				end
			end
			default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### src/amp_check.sv
// Port checker for the affine unit and its bind to the top level.
module amp_check (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input amp_pkg::req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input amp_pkg::rsp_t rsp
);
	import amp_pkg::*;

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// a transfer in makes the block busy on the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("block took a transfer and stayed free");

	// a singular result (invert or inverse transform) reports no point
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.singular |-> rsp.res_x == '0 && rsp.res_y == '0)
		else $error("singular result carries a point");

	// compare and singular never come from the same opcode
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.is_same && rsp.singular))
		else $error("compare and singular flags both set");

	// identity has determinant one
	a_ident_det: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_ident |-> rsp.det_value == Q_ONE)
		else $error("identity with wrong determinant");

endmodule

bind affine_matrix_point_unit amp_check u_amp_check (.*);
